>>> src/uwf_pkg.sv
`default_nettype none
package uwf_pkg;
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    localparam logic [3:0] REG_DATA = 4'd0;
    localparam logic [3:0] REG_IER  = 4'd1;
    localparam logic [3:0] REG_IIR  = 4'd2;
    localparam logic [3:0] REG_LCR  = 4'd3;
    localparam logic [3:0] REG_MCR  = 4'd4;
    localparam logic [3:0] REG_CTRL = 4'd8;
    localparam logic [3:0] REG_STAT = 4'd9;
    localparam logic [3:0] REG_DIV  = 4'd10;

    localparam logic [3:0] RX_AWAIT_START = 4'd15;

    typedef struct packed {
        logic rx_en;
        logic word8;
    } t_rx_ctl;
endpackage
`default_nettype wire

>>> src/uwf_rx.sv
`default_nettype none
module uwf_rx
    import uwf_pkg::*;
#(
    parameter int DIVISOR_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_tick,
    input  wire logic                    i_line,
    input  wire t_rx_ctl                 i_ctl,
    input  wire logic [DIVISOR_BITS+3:0] i_period,
    output logic                         o_done,
    output logic [7:0]                   o_byte
);
    localparam int CW = DIVISOR_BITS + 3;
    localparam int PW = DIVISOR_BITS + 4;

    logic [3:0]    r_left, n_left;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_shift, n_shift;
    logic [PW-1:0] target;

    assign target = (r_left == RX_AWAIT_START) ? (i_period >> 1) : i_period;

    always_comb begin
        n_left  = r_left;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        o_done  = 1'b0;
        o_byte  = i_ctl.word8 ? r_shift : {1'b0, r_shift[7:1]};
        if (i_tick) begin
            if (!i_ctl.rx_en) begin
                n_left = 4'd0;
                n_cnt  = '0;
            end else if (r_left == 4'd0) begin
                if (!i_line) begin
                    n_left = RX_AWAIT_START;
                    n_cnt  = '0;
                end
            end else if ({1'b0, r_cnt} + PW'(1) < target) begin
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_cnt = '0;
                if (r_left == RX_AWAIT_START) begin
                    if (i_line) begin
                        n_left = 4'd0;
                    end else begin
                        n_left  = i_ctl.word8 ? 4'd9 : 4'd8;
                        n_shift = 8'd0;
                    end
                end else if (r_left >= 4'd2) begin
                    n_shift = {i_line, r_shift[7:1]};
                    n_left  = r_left - 4'd1;
                end else begin
                    o_done = 1'b1;
                    n_left = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 4'd0;
            r_cnt   <= '0;
            r_shift <= 8'd0;
        end else begin
            r_left  <= n_left;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
        end
    end
endmodule
`default_nettype wire

>>> src/uart_with_fifos_regs_unit.sv
// UART with 8N1 or 7N1 framing (LCR bit 0) and receive/transmit FIFOs, driven by items.
// Input channel (i_valid/o_ready): one item per accepted handshake:
//   i_cmd tick (advance baud counters, sample i_rx_line), register read,
//   or register write (i_addr word index, i_wdata), or no-op.
// Output channel (o_valid/i_ready): one result per item: o_rdata (zero on
//   ticks, writes and no-ops), o_tx_line, o_rts_n and o_irq after the item.
// Result path: the item is registered on accept, and its result is written to
//   the output register when the output can advance (is not stalled).
// Throughput: one item per cycle while the output is not stalled; the limit is
//   the single state update between the input register and the result register.
// A serial bit lasts 8*(divisor+1) ticks.
// Reset clears FIFOs, divisor and counters and sets both enables (transmit and
//   receive enabled); FIFO contents are undefined until written.
// When the receiver stalls the output register holds; the input register
//   still takes one item while the result waits, then o_ready drops.
`default_nettype none
module uart_with_fifos_regs_unit
    import uwf_pkg::*;
#(
    parameter int FIFO_DEPTH   = 8,
    parameter int DIVISOR_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_addr,
    input  wire logic [15:0] i_wdata,
    input  wire logic        i_rx_line,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_rdata,
    output logic             o_tx_line,
    output logic             o_rts_n,
    output logic             o_irq
);
    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FW = $clog2(FIFO_DEPTH + 1);
    localparam int CW = DIVISOR_BITS + 3;
    localparam int PW = DIVISOR_BITS + 4;
    localparam logic [FW-1:0] FULL = FW'(FIFO_DEPTH);

    // input register
    logic        r_in_v;
    logic [1:0]  r_cmd;
    logic [3:0]  r_addr;
    logic [15:0] r_wdata;
    logic        r_line;
    logic        adv;

    assign adv     = !o_valid || i_ready;
    assign o_ready = !r_in_v || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd   <= i_cmd;
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
            r_line  <= i_rx_line;
        end
    end

    logic go;
    logic is_tick, is_rd, is_wr;
    assign go      = r_in_v && adv;
    assign is_tick = go && (t_cmd'(r_cmd) == CMD_TICK);
    assign is_rd   = go && (t_cmd'(r_cmd) == CMD_READ);
    assign is_wr   = go && (t_cmd'(r_cmd) == CMD_WRITE);

    // state
    logic [7:0]              rx_mem [FIFO_DEPTH];
    logic [7:0]              tx_mem [FIFO_DEPTH];
    logic [FW-1:0]           r_rx_fill, n_rx_fill, r_tx_fill, n_tx_fill;
    logic [AW-1:0]           r_rx_head, n_rx_head, r_tx_head, n_tx_head;
    logic [1:0]              r_ier, n_ier, r_xen, n_xen;
    logic                    r_word8, n_word8, r_rts, n_rts;
    logic [DIVISOR_BITS-1:0] r_div, n_div;
    logic [9:0]              r_tsh, n_tsh;
    logic [3:0]              r_tleft, n_tleft;
    logic [CW-1:0]           r_tcnt, n_tcnt;
    logic [PW-1:0]           period;

    assign period = {1'b0, r_div, 3'b000} + PW'(8);

    t_rx_ctl    rx_ctl;
    logic       rx_done;
    logic [7:0] rx_byte;
    assign rx_ctl = '{rx_en: r_xen[1], word8: r_word8};

    uwf_rx #(.DIVISOR_BITS(DIVISOR_BITS)) u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (is_tick),
        .i_line   (r_line),
        .i_ctl    (rx_ctl),
        .i_period (period),
        .o_done   (rx_done),
        .o_byte   (rx_byte)
    );

    logic [AW-1:0] rx_tail, tx_tail;
    logic          rx_push, tx_push;
    logic [7:0]    tx_head_byte, rx_head_byte;
    logic [15:0]   rd;
    logic          irx, itx;
    logic [3:0]    tl;

    assign tx_head_byte = tx_mem[r_tx_head];
    assign rx_head_byte = rx_mem[r_rx_head];
    assign irx = r_ier[0] && (r_rx_fill != '0);
    assign itx = r_ier[1] && (r_tx_fill == '0);

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] d;
        d = (AW+1)'(FIFO_DEPTH);
        return (v >= d) ? AW'(v - d) : AW'(v);
    endfunction

    assign rx_tail = wrap({1'b0, r_rx_head} + (AW+1)'(r_rx_fill));
    assign tx_tail = wrap({1'b0, r_tx_head} + (AW+1)'(r_tx_fill));

    always_comb begin
        n_rx_fill = r_rx_fill; n_tx_fill = r_tx_fill;
        n_rx_head = r_rx_head; n_tx_head = r_tx_head;
        n_ier = r_ier; n_xen = r_xen; n_word8 = r_word8; n_rts = r_rts;
        n_div = r_div; n_tsh = r_tsh; n_tleft = r_tleft; n_tcnt = r_tcnt;
        rx_push = 1'b0; tx_push = 1'b0; rd = 16'd0; tl = r_tleft;
        if (is_tick) begin
            if (r_tleft != 4'd0) begin
                if ({1'b0, r_tcnt} + PW'(1) >= period) begin
                    n_tsh  = {1'b1, r_tsh[9:1]};
                    tl     = r_tleft - 4'd1;
                    n_tcnt = '0;
                end else begin
                    n_tcnt = r_tcnt + CW'(1);
                end
            end
            n_tleft = tl;
            if (tl == 4'd0) begin
                n_tsh = 10'h3FF;
                if (r_xen[0] && r_tx_fill != '0) begin
                    n_tx_head = wrap({1'b0, r_tx_head} + (AW+1)'(1));
                    n_tx_fill = r_tx_fill - FW'(1);
                    n_tcnt    = '0;
                    if (r_word8) begin
                        n_tsh   = {1'b1, tx_head_byte, 1'b0};
                        n_tleft = 4'd10;
                    end else begin
                        n_tsh   = {2'b11, tx_head_byte[6:0], 1'b0};
                        n_tleft = 4'd9;
                    end
                end
            end
            if (rx_done && r_rx_fill < FULL) begin
                rx_push   = 1'b1;
                n_rx_fill = r_rx_fill + FW'(1);
            end
        end
        if (is_rd) begin
            case (r_addr)
                REG_DATA: begin
                    if (r_rx_fill != '0) begin
                        rd        = {8'd0, rx_head_byte};
                        n_rx_head = wrap({1'b0, r_rx_head} + (AW+1)'(1));
                        n_rx_fill = r_rx_fill - FW'(1);
                    end
                end
                REG_IER:  rd = {14'd0, r_ier};
                REG_IIR:  rd = {13'd0, irx, itx, !(irx || itx)};
                REG_LCR:  rd = {15'd0, r_word8};
                REG_MCR:  rd = {14'd0, r_rts, 1'b0};
                REG_CTRL: rd = {14'd0, r_xen};
                REG_STAT: rd = {10'd0, r_tx_fill >= FULL, 1'b0,
                                (r_tx_fill == '0) && (r_tleft == 4'd0), 1'b0,
                                r_tx_fill < FULL, r_rx_fill != '0};
                REG_DIV:  rd = 16'(r_div);
                default:  rd = 16'd0;
            endcase
        end
        if (is_wr) begin
            case (r_addr)
                REG_DATA: begin
                    if (r_tx_fill < FULL) begin
                        tx_push   = 1'b1;
                        n_tx_fill = r_tx_fill + FW'(1);
                    end
                end
                REG_IER: n_ier = r_wdata[1:0];
                REG_IIR: begin
                    if (r_wdata[1]) begin
                        n_rx_fill = '0;
                        n_rx_head = '0;
                    end
                    if (r_wdata[2]) begin
                        n_tx_fill = '0;
                        n_tx_head = '0;
                    end
                end
                REG_LCR:  n_word8 = r_wdata[0];
                REG_MCR:  n_rts   = r_wdata[1];
                REG_CTRL: n_xen   = r_wdata[1:0];
                REG_DIV:  n_div   = DIVISOR_BITS'(r_wdata);
                default:  n_rts   = r_rts;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_push) rx_mem[rx_tail] <= rx_byte;
        if (tx_push) tx_mem[tx_tail] <= r_wdata[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_fill <= '0; r_tx_fill <= '0; r_rx_head <= '0; r_tx_head <= '0;
            r_ier <= 2'd0; r_xen <= 2'd3; r_word8 <= 1'b0; r_rts <= 1'b0;
            r_div <= '0; r_tsh <= 10'h3FF; r_tleft <= 4'd0; r_tcnt <= '0;
            o_valid <= 1'b0;
        end else begin
            r_rx_fill <= n_rx_fill; r_tx_fill <= n_tx_fill;
            r_rx_head <= n_rx_head; r_tx_head <= n_tx_head;
            r_ier <= n_ier; r_xen <= n_xen; r_word8 <= n_word8; r_rts <= n_rts;
            r_div <= n_div; r_tsh <= n_tsh; r_tleft <= n_tleft; r_tcnt <= n_tcnt;
            if (adv) o_valid <= r_in_v;
        end
        if (go) begin
            o_rdata   <= rd;
            o_tx_line <= n_tsh[0];
            o_rts_n   <= !n_rts;
            o_irq     <= (n_ier[0] && n_rx_fill != '0) || (n_ier[1] && n_tx_fill == '0);
        end
    end
endmodule
`default_nettype wire

>>> src/uwf_check.sv
`default_nettype none
module uwf_check
    import uwf_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [1:0]  i_cmd,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_rdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rdata))
        else $error("result changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready with empty output");
    a_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && t_cmd'(i_cmd) != CMD_READ && (!o_valid || i_ready) ##1
        (!o_valid || i_ready) |=> o_rdata == 16'd0)
        else $error("nonzero rdata for non-read");
endmodule

bind uart_with_fifos_regs_unit uwf_check u_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_cmd(i_cmd), .o_valid(o_valid), .i_ready(i_ready), .o_rdata(o_rdata)
);
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
    import uwf_pkg::*;

    localparam int DEPTH = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [3:0]  i_addr;
    logic [15:0] i_wdata;
    logic        i_rx_line;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_rdata;
    logic        o_tx_line;
    logic        o_rts_n;
    logic        o_irq;

    uart_with_fifos_regs_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_addr(i_addr), .i_wdata(i_wdata), .i_rx_line(i_rx_line),
        .o_valid(o_valid), .i_ready(i_ready), .o_rdata(o_rdata),
        .o_tx_line(o_tx_line), .o_rts_n(o_rts_n), .o_irq(o_irq)
    );

    typedef struct packed {
        logic [15:0] rdata;
        logic        tx_line;
        logic        rts_n;
        logic        irq;
    } t_uart_out;

    t_uart_out pending_outs[$];

    logic [7:0]  m_rx_mem[DEPTH];
    logic [7:0]  m_tx_mem[DEPTH];
    int          m_rx_fill, m_tx_fill, m_rx_head, m_tx_head;
    logic [1:0]  m_ier;
    logic        m_word8, m_rts;
    logic [1:0]  m_ctrl;
    logic [15:0] m_div;
    logic [9:0]  m_tx_sr;
    int          m_tx_left;
    longint      m_tx_cnt;
    logic [7:0]  m_rx_sr;
    int          m_rx_left;
    longint      m_rx_cnt;

    int          err_count;
    int          idle_pct_src, idle_pct_dst;
    int          quiet_cycles;
    bit          timed_out;
    logic        line_level;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic irq_rx_now();
        return m_ier[0] && m_rx_fill > 0;
    endfunction

    function automatic logic irq_tx_now();
        return m_ier[1] && m_tx_fill == 0;
    endfunction

    task automatic uart_reset_state();
        m_rx_fill = 0; m_tx_fill = 0; m_rx_head = 0; m_tx_head = 0;
        m_ier = '0; m_word8 = 1'b0; m_rts = 1'b0; m_ctrl = 2'b11; m_div = '0;
        m_tx_sr = '1; m_tx_left = 0; m_tx_cnt = 0;
        m_rx_sr = '0; m_rx_left = 0; m_rx_cnt = 0;
    endtask

    function automatic void uart_tick(input logic line);
        longint per;
        longint target;
        logic [7:0] b;
        per = 8 * (longint'(m_div) + 1);
        if (m_tx_left != 0) begin
            if (m_tx_cnt + 1 >= per) begin
                m_tx_sr = {1'b1, m_tx_sr[9:1]};
                m_tx_left--;
                m_tx_cnt = 0;
            end else begin
                m_tx_cnt++;
            end
        end
        if (m_tx_left == 0) begin
            m_tx_sr = '1;
            if (m_ctrl[0] && m_tx_fill > 0) begin
                b = m_tx_mem[m_tx_head];
                m_tx_head = (m_tx_head + 1) % DEPTH;
                m_tx_fill--;
                if (m_word8) begin
                    m_tx_sr = {1'b1, b, 1'b0};
                    m_tx_left = 10;
                end else begin
                    m_tx_sr = {2'b11, b[6:0], 1'b0};
                    m_tx_left = 9;
                end
                m_tx_cnt = 0;
            end
        end
        if (!m_ctrl[1]) begin
            m_rx_left = 0;
            m_rx_cnt = 0;
        end else if (m_rx_left == 0) begin
            if (!line) begin
                m_rx_left = RX_AWAIT_START;
                m_rx_cnt = 0;
            end
        end else begin
            target = (m_rx_left == RX_AWAIT_START) ? per / 2 : per;
            if (m_rx_cnt + 1 < target) begin
                m_rx_cnt++;
            end else begin
                m_rx_cnt = 0;
                if (m_rx_left == RX_AWAIT_START) begin
                    if (line) begin
                        m_rx_left = 0;
                    end else begin
                        m_rx_left = m_word8 ? 9 : 8;
                        m_rx_sr = '0;
                    end
                end else if (m_rx_left >= 2) begin
                    m_rx_sr = {line, m_rx_sr[7:1]};
                    m_rx_left--;
                end else begin
                    b = m_word8 ? m_rx_sr : {1'b0, m_rx_sr[7:1]};
                    if (m_rx_fill < DEPTH) begin
                        m_rx_mem[(m_rx_head + m_rx_fill) % DEPTH] = b;
                        m_rx_fill++;
                    end
                    m_rx_left = 0;
                end
            end
        end
    endfunction

    function automatic logic [15:0] uart_read(input logic [3:0] a);
        logic [15:0] v;
        v = '0;
        case (a)
            REG_DATA: begin
                if (m_rx_fill > 0) begin
                    v = {8'h00, m_rx_mem[m_rx_head]};
                    m_rx_head = (m_rx_head + 1) % DEPTH;
                    m_rx_fill--;
                end
            end
            REG_IER:  v = {14'd0, m_ier};
            REG_IIR:  v = {13'd0, irq_rx_now(), irq_tx_now(), !(irq_rx_now() || irq_tx_now())};
            REG_LCR:  v = {15'd0, m_word8};
            REG_MCR:  v = {14'd0, m_rts, 1'b0};
            REG_CTRL: v = {14'd0, m_ctrl};
            REG_STAT: v = {10'd0, m_tx_fill >= DEPTH, 1'b0,
                           m_tx_fill == 0 && m_tx_left == 0, 1'b0,
                           m_tx_fill < DEPTH, m_rx_fill > 0};
            REG_DIV:  v = m_div;
            default:  v = '0;
        endcase
        return v;
    endfunction

    function automatic void uart_write(input logic [3:0] a, input logic [15:0] w);
        case (a)
            REG_DATA: begin
                if (m_tx_fill < DEPTH) begin
                    m_tx_mem[(m_tx_head + m_tx_fill) % DEPTH] = w[7:0];
                    m_tx_fill++;
                end
            end
            REG_IER:  m_ier = w[1:0];
            REG_IIR: begin
                if (w[1]) begin
                    m_rx_fill = 0;
                    m_rx_head = 0;
                end
                if (w[2]) begin
                    m_tx_fill = 0;
                    m_tx_head = 0;
                end
            end
            REG_LCR:  m_word8 = w[0];
            REG_MCR:  m_rts = w[1];
            REG_CTRL: m_ctrl = w[1:0];
            REG_DIV:  m_div = w;
            default: ;
        endcase
    endfunction

    function automatic t_uart_out uart_apply(input t_cmd c, input logic [3:0] a,
                                             input logic [15:0] w, input logic line);
        t_uart_out r;
        r.rdata = '0;
        case (c)
            CMD_TICK:  uart_tick(line);
            CMD_READ:  r.rdata = uart_read(a);
            CMD_WRITE: uart_write(a, w);
            default: ;
        endcase
        r.tx_line = m_tx_sr[0];
        r.rts_n = !m_rts;
        r.irq = irq_rx_now() || irq_tx_now();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    task automatic send_item(input t_cmd c, input logic [3:0] a, input logic [15:0] w,
                             input logic line);
        while (idle_pct_src > 0 && $urandom_range(99) < idle_pct_src) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        i_addr <= a;
        i_wdata <= w;
        i_rx_line <= line;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_outs.push_back(uart_apply(c, a, w, line));
        @(negedge i_clk);
    endtask

    task automatic reg_wr(input logic [3:0] a, input logic [15:0] w);
        send_item(CMD_WRITE, a, w, line_level);
    endtask

    task automatic reg_rd(input logic [3:0] a);
        send_item(CMD_READ, a, 16'h0000, line_level);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_outs.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_serial_byte(input logic [7:0] b, input int bits, input bit stop);
        int per;
        per = 8 * (int'(m_div) + 1);
        repeat (per) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b0);
        for (int i = 0; i < bits; i++) begin
            repeat (per) send_item(CMD_TICK, 4'd0, 16'h0000, b[i]);
        end
        repeat (per) send_item(CMD_TICK, 4'd0, 16'h0000, stop);
        line_level = 1'b1;
    endtask

    task automatic test_registers();
        reg_wr(REG_IER, 16'hFFFF);
        reg_rd(REG_IER);
        reg_rd(REG_IIR);
        reg_wr(REG_LCR, 16'hFFFF);
        reg_rd(REG_LCR);
        reg_wr(REG_MCR, 16'hFFFF);
        reg_rd(REG_MCR);
        reg_wr(REG_MCR, 16'h0000);
        reg_wr(REG_DIV, 16'hFFFF);
        reg_rd(REG_DIV);
        reg_wr(REG_DATA, 16'h0055);
        repeat (6) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b0);
        repeat (6) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_rd(REG_STAT);
        reg_wr(REG_DIV, 16'h0000);
        send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_wr(REG_STAT, 16'hFFFF);
        reg_rd(REG_STAT);
        reg_wr(4'd15, 16'hFFFF);
        reg_rd(4'd15);
        reg_rd(REG_DATA);
        send_item(CMD_NOP, 4'd5, 16'hAAAA, 1'b1);
        reg_wr(REG_CTRL, 16'h0000);
        reg_rd(REG_CTRL);
        reg_wr(REG_CTRL, 16'h0003);
        wait_drained();
    endtask

    task automatic test_tx_fifo();
        for (int i = 0; i < 10; i++) reg_wr(REG_DATA, 16'hFF00 | 16'(i * 53));
        reg_rd(REG_STAT);
        reg_wr(REG_LCR, 16'h0000);
        repeat (30) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_wr(REG_CTRL, 16'h0002);
        repeat (30) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_rd(REG_STAT);
        reg_wr(REG_IIR, 16'h0004);
        reg_wr(REG_CTRL, 16'h0003);
        repeat (20) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_rd(REG_STAT);
        wait_drained();
    endtask

    task automatic test_rx_frames();
        reg_wr(REG_LCR, 16'h0001);
        send_serial_byte(8'h3C, 8, 1'b0);
        reg_wr(REG_LCR, 16'h0000);
        send_serial_byte(8'hA5, 7, 1'b1);
        repeat (2) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b0);
        repeat (4) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_rd(REG_IIR);
        for (int i = 0; i < 3; i++) reg_rd(REG_DATA);
        reg_wr(REG_CTRL, 16'h0001);
        repeat (8) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b0);
        reg_wr(REG_CTRL, 16'h0003);
        repeat (4) send_item(CMD_TICK, 4'd0, 16'h0000, 1'b1);
        reg_rd(REG_STAT);
        reg_wr(REG_LCR, 16'h0001);
        wait_drained();
    endtask

    task automatic random_item();
        int pick;
        logic [3:0] a;
        pick = $urandom_range(99);
        a = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
            4'($urandom_range(10));
        if (pick < 55) begin
            if ($urandom_range(3) == 0) line_level = ~line_level;
            send_item(CMD_TICK, 4'($urandom), 16'($urandom), line_level);
        end else if (pick < 75) begin
            send_item(CMD_READ, a, 16'($urandom), line_level);
        end else if (pick < 97) begin
            if (a == REG_DIV) reg_wr(REG_DIV, 16'($urandom_range(1)));
            else if (a == REG_CTRL) reg_wr(REG_CTRL, ($urandom_range(4) == 0) ?
                                          16'($urandom) : 16'hFFFF);
            else reg_wr(a, 16'($urandom));
        end else begin
            send_item(CMD_NOP, 4'($urandom), 16'($urandom), line_level);
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct_src = (ph == 1 || ph == 3) ? 64 : (ph == 3 ? 13 : 0);
            idle_pct_dst = (ph == 2) ? 64 : 0;
            if (ph == 3) begin
                idle_pct_src = 13;
                idle_pct_dst = 13;
            end
            reg_wr(REG_DIV, 16'h0000);
            for (int n = 0; n < 10; n++) begin
                random_item();
                random_item();
            end
            if (ph == 1) wait_drained();
            reg_rd(REG_STAT);
            while (m_rx_fill > 0) reg_rd(REG_DATA);
        end
        idle_pct_src = 0;
        idle_pct_dst = 0;
    endtask

    always @(negedge i_clk) begin
        if (idle_pct_dst > 0) i_ready <= ($urandom_range(99) >= idle_pct_dst);
        else i_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_uart_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outs.size() == 0) begin
                report_mismatch("unexpected result", o_rdata, 16'h0000);
            end else begin
                want = pending_outs.pop_front();
                if (o_rdata !== want.rdata) report_mismatch("rdata", o_rdata, want.rdata);
                if (o_tx_line !== want.tx_line)
                    report_mismatch("tx_line", 16'(o_tx_line), 16'(want.tx_line));
                if (o_rts_n !== want.rts_n)
                    report_mismatch("rts_n", 16'(o_rts_n), 16'(want.rts_n));
                if (o_irq !== want.irq) report_mismatch("irq", 16'(o_irq), 16'(want.irq));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        err_count = 0;
        timed_out = 1'b0;
        quiet_cycles = 0;
        idle_pct_src = 0;
        idle_pct_dst = 0;
        line_level = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_TICK;
        i_addr = '0;
        i_wdata = '0;
        i_rx_line = 1'b1;
        i_ready = 1'b1;
        uart_reset_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_registers();
        test_tx_fifo();
        test_rx_frames();
        test_random();
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (err_count == 0 && pending_outs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> uart_with_fifos_regs_unit.f
src/uwf_pkg.sv
src/uwf_rx.sv
src/uart_with_fifos_regs_unit.sv
src/uwf_check.sv
sim/testbench.sv
